>>> rtl/hsv_to_rgb_converter_macros.svh
// Assertion macros used by the converter's checker.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Clocked check, muted while reset is high.
`define HSV2RGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define HSV2RGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/hsv2rgb_pkg.sv
// Types and constants of the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam logic [8:0] HueTurn   = 9'd360;
  localparam logic [8:0] HueSector = 9'd60;
  localparam logic [5:0] HueSpan   = 6'd60;
  localparam logic [7:0] UnitScale = 8'd255;

  // floor(x / 255) == (x * LowRecip) >> LowShift for x <= 255 * 255
  localparam logic [16:0] LowRecip = 17'd65794;
  localparam int          LowShift = 24;

  // floor(x / 15300) == (x * MidRecip) >> MidShift for x <= 255 * 15300
  localparam logic [22:0] MidRecip = 23'd4491470;
  localparam int          MidShift = 36;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t    sector;
    logic [5:0] ramp;
  } hue_info_t;

endpackage

>>> rtl/hsv2rgb_if.sv
// Valid/ready channel interfaces for HSV requests and RGB results.
`timescale 1ns / 1ps

interface hsv_pixel_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue_deg;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, hue_deg, saturation, brightness, input ready);
  modport sink   (input valid, hue_deg, saturation, brightness, output ready);
endinterface

interface rgb_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsv2rgb_hue.sv
// Hue decode: wrap to one turn, pick the sector and the ramp position in it.
`timescale 1ns / 1ps

module hsv2rgb_hue import hsv2rgb_pkg::*; (
  input  logic [8:0] hue_deg,
  output hue_info_t  info
);

  localparam logic [8:0] Start1 = HueSector;
  localparam logic [8:0] Start2 = 9'(2 * HueSector);
  localparam logic [8:0] Start3 = 9'(3 * HueSector);
  localparam logic [8:0] Start4 = 9'(4 * HueSector);
  localparam logic [8:0] Start5 = 9'(5 * HueSector);

  logic [8:0] hue;
  logic [8:0] base;
  logic [5:0] offset;
  sector_t    sector;

  always_comb begin
    hue = (hue_deg >= HueTurn) ? 9'(hue_deg - HueTurn) : hue_deg;
    priority if (hue >= Start5) begin
      sector = SEC_MAG_RED;
      base   = Start5;
    end else if (hue >= Start4) begin
      sector = SEC_BLU_MAG;
      base   = Start4;
    end else if (hue >= Start3) begin
      sector = SEC_CYN_BLU;
      base   = Start3;
    end else if (hue >= Start2) begin
      sector = SEC_GRN_CYN;
      base   = Start2;
    end else if (hue >= Start1) begin
      sector = SEC_YEL_GRN;
      base   = Start1;
    end else begin
      sector = SEC_RED_YEL;
      base   = '0;
    end
    offset = 6'(hue - base);
    // odd sectors ramp down
    info.sector = sector;
    info.ramp   = sector[0] ? 6'(HueSpan - offset) : offset;
  end

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB pixel converter.
`timescale 1ns / 1ps

// Usage:
//   hsv is the request channel: hue_deg (0..359, 360..511 wraps by one turn),
//   saturation and brightness (255 = 1.0). rgb is the result channel with the
//   8-bit red, green and blue of that pixel. Both use valid/ready; a transfer
//   happens on a rising clk edge with valid and ready high.
//   Throughput: one pixel per clock cycle, sustained, while rgb.ready is high.
//   A request passes through five register stages (hue decode, two
//   products, chroma product with the floor divide, ramp divide, component
//   select into the output register) before rgb.valid rises.
//   Each component is the exact floor of the real-valued conversion.
//   Stall: when rgb holds a result that is not taken, the whole pipeline
//   holds and hsv.ready drops; hsv.ready is high whenever the output register
//   is empty or being taken, so a new request enters in the same cycle that a
//   stalled result leaves. Nothing is dropped or repeated.
//   Reset (rst, synchronous, active high) empties every stage; results in
//   flight are dropped and hsv.ready is high from the first reset edge on.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input logic         clk,
  input logic         rst,
  hsv_pixel_if.sink   hsv,
  rgb_pixel_if.source rgb
);

  // Whole pipeline moves together; it only holds for a stalled result.
  logic advance;

  // Stage valid bits.
  logic vld1, vld2, vld3, vld4, vld5;

  // Stage 1: hue decoded, inputs split.
  hue_info_t  hue_info;
  sector_t    sec1;
  logic [5:0] ramp1;
  logic [7:0] sat1, inv_sat1, val1;

  // Stage 2: first products.
  sector_t     sec2;
  logic [7:0]  val2;
  logic [13:0] weight2;   // s * ramp + (255 - s) * 60, at most 15300
  logic [15:0] grey2;     // v * (255 - s)

  // Stage 3: chroma ramp product, floor component.
  sector_t     sec3;
  logic [7:0]  val3;
  logic [21:0] ramp_num3;
  logic [7:0]  low3;

  // Stage 4: ramp component.
  sector_t     sec4;
  logic [7:0]  val4, low4, mid4;

  // Stage 5: output register.
  logic [7:0]  red, green, blue;

  logic [13:0] sat_ramp, inv_sat_span;
  logic [32:0] low_prod;
  logic [44:0] mid_prod;

  assign advance   = !vld5 || rgb.ready;
  assign hsv.ready = advance;

  hsv2rgb_hue u_hue (
    .hue_deg (hsv.hue_deg),
    .info    (hue_info)
  );

  // Control: valid bits shift with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else if (advance) begin
      vld1 <= hsv.valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
    end
  end

  always_comb begin
    sat_ramp     = 14'(sat1) * 14'(ramp1);
    inv_sat_span = 14'(inv_sat1) * 14'(HueSpan);
    low_prod     = 33'(grey2) * 33'(LowRecip);
    mid_prod     = 45'(ramp_num3) * 45'(MidRecip);
  end

  // Datapath: no reset needed, loaded only when the pipeline advances.
  always_ff @(posedge clk) begin
    if (advance) begin
      // stage 1
      sec1     <= hue_info.sector;
      ramp1    <= hue_info.ramp;
      sat1     <= hsv.saturation;
      inv_sat1 <= 8'(UnitScale - hsv.saturation);
      val1     <= hsv.brightness;
      // stage 2
      sec2     <= sec1;
      val2     <= val1;
      weight2  <= 14'(sat_ramp + inv_sat_span);
      grey2    <= 16'(val1) * 16'(inv_sat1);
      // stage 3
      sec3      <= sec2;
      val3      <= val2;
      ramp_num3 <= 22'(val2) * 22'(weight2);
      low3      <= low_prod[LowShift +: 8];
      // stage 4
      sec4 <= sec3;
      val4 <= val3;
      low4 <= low3;
      mid4 <= mid_prod[MidShift +: 8];
      // stage 5: route top, ramp and floor to the channels by sector
      unique case (sec4)
        SEC_RED_YEL: begin
          red <= val4; green <= mid4; blue <= low4;
        end
        SEC_YEL_GRN: begin
          red <= mid4; green <= val4; blue <= low4;
        end
        SEC_GRN_CYN: begin
          red <= low4; green <= val4; blue <= mid4;
        end
        SEC_CYN_BLU: begin
          red <= low4; green <= mid4; blue <= val4;
        end
        SEC_BLU_MAG: begin
          red <= mid4; green <= low4; blue <= val4;
        end
        default: begin
          red <= val4; green <= low4; blue <= mid4;
        end
      endcase
    end
  end

  assign rgb.valid = vld5;
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

endmodule

>>> rtl/hsv2rgb_chk.sv
// Port-level checker for the HSV to RGB converter and its bind.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_macros.svh"

module hsv2rgb_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // Reset empties the pipeline.
  `HSV2RGB_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "result valid right after reset")

  // A stalled result holds.
  `HSV2RGB_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable({red, green, blue}), "stalled result changed")

  // Only a stalled result may hold back requests.
  `HSV2RGB_ASSERT(a_ready_rule, in_ready == (!out_valid || out_ready), "request ready wrong")

  // With the output stalled, no request is taken.
  `HSV2RGB_ASSERT(a_no_take_on_stall, out_valid && !out_ready && in_valid |-> !in_ready, "request taken while stalled")

endmodule

bind hsv_to_rgb_converter hsv2rgb_chk u_hsv2rgb_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hsv.valid),
  .in_ready  (hsv.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .red       (rgb.red),
  .green     (rgb.green),
  .blue      (rgb.blue)
);
